### src/sfm_pkg.sv
`timescale 1ns / 1ps

package sfm_pkg;

   localparam int DATA_WIDTH = 32;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] dividend;
      logic signed [DATA_WIDTH-1:0] divisor;
   } sfm_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] modulo;
      logic                         divide_by_zero;
   } sfm_rsp_type;

   // Word carried between divider stages: partial remainder, the dividend bits
   // still to be consumed (MSB first) and the sign information for the fix-up.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] dvd;
      logic [DATA_WIDTH-1:0] mag_b;
      logic                  neg_a;
      logic                  neg_b;
      logic                  div_zero;
   } sfm_stage_type;

endpackage

### src/sfm_prep.sv
`timescale 1ns / 1ps

module sfm_prep import sfm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  sfm_req_type   in_word,
   output logic          out_valid,
   output sfm_stage_type out_word
);

   logic          valid_ff;
   sfm_stage_type word_ff;
   sfm_stage_type word_in;

   // Take magnitudes; the most negative value maps onto 2^(W-1) unsigned.
   always_comb begin
      word_in.neg_a    = in_word.dividend[DATA_WIDTH-1];
      word_in.neg_b    = in_word.divisor[DATA_WIDTH-1];
      word_in.dvd      = word_in.neg_a ? (DATA_WIDTH'(0) - DATA_WIDTH'(in_word.dividend))
                                       : DATA_WIDTH'(in_word.dividend);
      word_in.mag_b    = word_in.neg_b ? (DATA_WIDTH'(0) - DATA_WIDTH'(in_word.divisor))
                                       : DATA_WIDTH'(in_word.divisor);
      word_in.rem      = '0;
      word_in.div_zero = (in_word.divisor == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Hold the payload while stalled.
   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### src/sfm_div_stage.sv
`timescale 1ns / 1ps

module sfm_div_stage import sfm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  sfm_stage_type in_word,
   output logic          out_valid,
   output sfm_stage_type out_word
);

   logic          valid_ff;
   sfm_stage_type word_ff;
   sfm_stage_type word_in;
   logic [DATA_WIDTH-1:0] shifted;

   // One restoring step: bring down the next dividend bit, subtract if it fits.
   // For a nonzero divisor the remainder stays below its magnitude, so its MSB is clear.
   always_comb begin
      word_in     = in_word;
      shifted     = {in_word.rem[DATA_WIDTH-2:0], in_word.dvd[DATA_WIDTH-1]};
      word_in.dvd = {in_word.dvd[DATA_WIDTH-2:0], 1'b0};
      if (shifted >= in_word.mag_b) begin
         word_in.rem = shifted - in_word.mag_b;
      end else begin
         word_in.rem = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### src/sfm_fixup.sv
`timescale 1ns / 1ps

module sfm_fixup import sfm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  sfm_stage_type in_word,
   output logic          out_valid,
   output sfm_rsp_type   out_word
);

   logic        valid_ff;
   sfm_rsp_type word_ff;
   sfm_rsp_type word_in;

   // Zero divisor gives 0; else restore the sign, then move a nonzero remainder over to the divisor's side.
   always_comb begin
      word_in.divide_by_zero = in_word.div_zero;
      if (in_word.div_zero) begin
         word_in.modulo = '0;
      end else if ((in_word.neg_a != in_word.neg_b) && (in_word.rem != '0)) begin
         word_in.modulo = in_word.neg_a ? (in_word.mag_b - in_word.rem)
                                        : (in_word.rem - in_word.mag_b);
      end else begin
         word_in.modulo = in_word.neg_a ? (DATA_WIDTH'(0) - in_word.rem) : in_word.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### src/signed_floored_modulo.sv
`timescale 1ns / 1ps
// Signed floored modulo, fully pipelined.
// Request channel: req_valid / req_stall carry a word holding dividend and
// divisor. Response channel: rsp_valid / rsp_stall carry a word holding the
// floored remainder (sign of the divisor when nonzero) and a divide-by-zero
// flag. A zero divisor gives modulo 0 with the flag set; the most negative
// value modulo minus one gives 0.
// Pipeline: one magnitude stage, one restoring subtract stage per dividend
// bit, one sign fix-up / output stage.
// Throughput: one word per cycle while not stalled; every stage holds its
// own word, so a new request is taken while earlier ones are in flight.
// Stall: when a response is held by rsp_stall, the whole pipeline freezes
// and req_stall rises; nothing is dropped or repeated. Bubbles flow through
// whenever the output register is empty or being emptied.
// Reset: synchronous, active high; clears every stage valid bit, so the
// pipeline comes up empty. Payload registers are not reset.

module signed_floored_modulo import sfm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sfm_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sfm_rsp_type rsp_word
);

   // Advance all stages together unless a finished word is being held.
   logic advance;

   sfm_stage_type stage_word  [0:DATA_WIDTH];
   logic          stage_valid [0:DATA_WIDTH];

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   sfm_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .out_valid (stage_valid[0]),
      .out_word  (stage_word[0])
   );

   // One stage per quotient bit, most significant first.
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_div
      sfm_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_word   (stage_word[i]),
         .out_valid (stage_valid[i+1]),
         .out_word  (stage_word[i+1])
      );
   end

   sfm_fixup u_fixup (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (stage_valid[DATA_WIDTH]),
      .in_word   (stage_word[DATA_WIDTH]),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule
